[src/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is high.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pointer classifier check failed");

// Concurrent assertion on the rising clock edge that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pointer classifier check failed");

`endif

[src/pcdc_pkg.sv]
package pcdc_pkg;

  // Design sizes.
  localparam int BUTTON_COUNT = 3;
  localparam int COORD_BITS   = 16;
  localparam int THR_W        = 16;
  localparam int TIME_W       = 32;
  localparam int IDX_W        = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int DIST_W       = (COORD_BITS + 1 > THR_W) ? COORD_BITS + 1 : THR_W;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  // Operation codes of a request.
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_DOUBLE  = 2'd2;
  localparam logic [1:0] OP_MOVE    = 2'd3;

  localparam logic [1:0] BTN_NONE = 2'd3;

  // Gesture codes of a result.
  localparam logic [2:0] G_MOVE       = 3'd0;
  localparam logic [2:0] G_DRAG_START = 3'd1;
  localparam logic [2:0] G_DRAG       = 3'd2;
  localparam logic [2:0] G_DRAG_END   = 3'd3;
  localparam logic [2:0] G_CLICK      = 3'd4;
  localparam logic [2:0] G_DOUBLE     = 3'd5;

  // Register indexes, taken from paddr[2].
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_DELAY     = 1'b1;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd4;
  localparam logic [TIME_W-1:0] DELAY_RESET     = 32'd300;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  button;
    coord_t      pos_x;
    coord_t      pos_y;
    logic [31:0] now_ms;
    logic        shift_held;
    logic        alt_held;
    logic        ctrl_held;
  } req_t;

  typedef struct packed {
    logic [2:0] gesture;
    logic [1:0] gesture_button;
    coord_t     out_x;
    coord_t     out_y;
    logic [2:0] modifier_code;
    logic       last_of_run;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL,
    S_OTHER
  } state_t;

  // Which result the datapath builds when it loads the output register.
  typedef enum logic [1:0] {
    EK_START,
    EK_FINAL,
    EK_OTHER
  } emit_kind_t;

  typedef struct packed {
    logic       load_in;
    logic       scan_clr;
    logic       scan_adv;
    logic       mark_drag;
    logic       apply;
    logic       emit;
    emit_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic       new_move;
    logic [1:0] op;
    logic       btn_ok;
    logic       held;
    logic       drag;
    logic       trig;
    logic       scan_last;
    logic       slot_free;
  } st_t;

  // Collapse the three modifier flags into one code.
  function automatic logic [2:0] mod_code(input logic s, input logic a, input logic c);
    logic [2:0] m;
    if (s && a && c)  m = 3'd7;
    else if (s && a)  m = 3'd4;
    else if (a && c)  m = 3'd5;
    else if (s && c)  m = 3'd6;
    else if (s)       m = 3'd1;
    else if (a)       m = 3'd2;
    else if (c)       m = 3'd3;
    else              m = 3'd0;
    return m;
  endfunction

endpackage

[src/pointer_click_drag_classifier.sv]
// Pointer click/drag classifier.
// Requests arrive on req_valid/req_ready/req_data (press, release, double click
// or move) and gestures leave on rsp_valid/rsp_ready/rsp_data, one result per
// handshake, the last result of a request marked by last_of_run.
// The APB port holds the drag distance threshold at address 0 and
// drag_delay_ms at address 4.
// A request is taken only while the controller is idle. A move walks the
// tracked buttons one per cycle while the output register can take each drag
// start, in S_SCAN, and then gives its final result in S_FINAL; it gives up
// to BUTTON_COUNT + 1 results. Press, release and double click are handled in
// S_OTHER, which loads a result into the output register where one is due.
// Every result goes through a single output register; when the receiver
// stalls with a result still held, the walk pauses at the next result and the
// block takes no new request until that walk is done.
// Reset clears all button marks, sets start points to -1 and start times to 0,
// restores the register defaults (threshold 4, delay 300) and empties the
// output register. No request is taken while reset is high.
module pointer_click_drag_classifier import pcdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cmd_t cmd;
  st_t  st;

  assign pready = 1'b1;

  // Sequencer.
  pcdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // Button state, comparators, registers and output stage.
  pcdc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_data  (req_data),
    .cmd       (cmd),
    .st        (st),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
  );

endmodule

[src/pcdc_ctrl.sv]
module pcdc_ctrl import pcdc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  st_t  st,
  output cmd_t cmd
);

  state_t state, state_next;
  logic   cand;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A scanned button starts a drag when it is pressed, not yet dragged and past a limit.
  assign cand = st.held && !st.drag && st.trig;

  // Next state and commands.
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '{default: '0, kind: EK_OTHER};
    case (state)
      S_IDLE: begin
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load_in  = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = st.new_move ? S_SCAN : S_OTHER;
        end
      end
      S_SCAN: begin
        if (cand) begin
          if (st.slot_free) begin
            cmd.emit      = 1'b1;
            cmd.kind      = EK_START;
            cmd.mark_drag = 1'b1;
            cmd.scan_adv  = 1'b1;
            if (st.scan_last) begin
              state_next = S_FINAL;
            end
          end
        end else begin
          cmd.scan_adv = 1'b1;
          if (st.scan_last) begin
            state_next = S_FINAL;
          end
        end
      end
      S_FINAL: begin
        if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = EK_FINAL;
          state_next = S_IDLE;
        end
      end
      S_OTHER: begin
        if (!st.btn_ok) begin
          state_next = S_IDLE;
        end else begin
          case (st.op)
            OP_PRESS: begin
              cmd.apply  = 1'b1;
              state_next = S_IDLE;
            end
            OP_RELEASE: begin
              if (!(st.held || st.drag)) begin
                state_next = S_IDLE;
              end else if (st.slot_free) begin
                cmd.emit   = 1'b1;
                cmd.apply  = 1'b1;
                state_next = S_IDLE;
              end
            end
            default: begin
              // Double click passes through.
              if (st.slot_free) begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/pcdc_datapath.sv]
module pcdc_datapath import pcdc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  req_t              req_data,
  input  cmd_t              cmd,
  output st_t               st,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata
);

  req_t                    cur;
  logic [BUTTON_COUNT-1:0] held_mark;
  logic [BUTTON_COUNT-1:0] drag_mark;
  coord_t                  anchor_x [BUTTON_COUNT];
  coord_t                  anchor_y [BUTTON_COUNT];
  logic [TIME_W-1:0]       press_time [BUTTON_COUNT];
  logic [IDX_W-1:0]        idx;
  logic [IDX_W-1:0]        best_idx;
  logic [TIME_W-1:0]       best_t;
  logic                    best_found;
  logic [THR_W-1:0]        drag_distance;
  logic [TIME_W-1:0]       drag_delay_ms;

  logic [IDX_W-1:0]        rd_addr;
  logic                    held_rd;
  logic                    drag_rd;
  coord_t                  ax_rd;
  coord_t                  ay_rd;
  logic [TIME_W-1:0]       pt_rd;
  logic [TIME_W-1:0]       elapsed;
  logic [COORD_BITS:0]     dx;
  logic [COORD_BITS:0]     dy;
  logic [COORD_BITS:0]     adx;
  logic [COORD_BITS:0]     ady;
  logic                    eff_drag;
  logic                    cfg_wr;
  rsp_t                    res;

  // Latched request.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur <= req_data;
    end
  end

  // Configuration registers.
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_distance <= THRESHOLD_RESET;
      drag_delay_ms <= DELAY_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_THRESHOLD) begin
        drag_distance <= pwdata[THR_W-1:0];
      end else begin
        drag_delay_ms <= pwdata[TIME_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_DELAY) ? drag_delay_ms
                                          : {{(DATA_W-THR_W){1'b0}}, drag_distance};

  // A move walks the buttons by the scan index; other requests use their own button.
  assign rd_addr = (cur.operation == OP_MOVE) ? idx : IDX_W'(cur.button);
  assign held_rd = held_mark[rd_addr];
  assign drag_rd = drag_mark[rd_addr];
  assign ax_rd   = anchor_x[rd_addr];
  assign ay_rd   = anchor_y[rd_addr];
  assign pt_rd   = press_time[rd_addr];

  // Drag trigger: wrapped hold time or per-axis distance from the start point.
  assign elapsed = cur.now_ms - pt_rd;
  assign dx      = {cur.pos_x[COORD_BITS-1], cur.pos_x} - {ax_rd[COORD_BITS-1], ax_rd};
  assign dy      = {cur.pos_y[COORD_BITS-1], cur.pos_y} - {ay_rd[COORD_BITS-1], ay_rd};
  assign adx     = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign ady     = dy[COORD_BITS] ? (~dy + 1'b1) : dy;

  always_comb begin
    st.new_move  = (req_data.operation == OP_MOVE);
    st.op        = cur.operation;
    st.btn_ok    = (cur.button != BTN_NONE) && (32'(cur.button) < BUTTON_COUNT);
    st.held      = held_rd;
    st.drag      = drag_rd;
    st.trig      = (elapsed >= drag_delay_ms)
                || (DIST_W'(adx) >= DIST_W'(drag_distance))
                || (DIST_W'(ady) >= DIST_W'(drag_distance));
    st.scan_last = (idx == IDX_W'(BUTTON_COUNT - 1));
    st.slot_free = !rsp_valid || rsp_ready;
  end

  // Per-button state.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_mark <= '0;
      drag_mark <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        anchor_x[i]   <= '1;
        anchor_y[i]   <= '1;
        press_time[i] <= '0;
      end
    end else begin
      if (cmd.mark_drag) begin
        drag_mark[rd_addr] <= 1'b1;
      end
      if (cmd.apply) begin
        if (cur.operation == OP_PRESS) begin
          held_mark[rd_addr]  <= 1'b1;
          anchor_x[rd_addr]   <= cur.pos_x;
          anchor_y[rd_addr]   <= cur.pos_y;
          press_time[rd_addr] <= cur.now_ms;
        end else begin
          held_mark[rd_addr] <= 1'b0;
          drag_mark[rd_addr] <= 1'b0;
        end
      end
    end
  end

  // Scan index and running pick of the latest started drag.
  assign eff_drag = drag_rd || cmd.mark_drag;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      best_idx   <= '0;
      best_t     <= '0;
      best_found <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx        <= '0;
      best_t     <= '0;
      best_found <= 1'b0;
    end else if (cmd.scan_adv) begin
      if (!st.scan_last) begin
        idx <= idx + 1'b1;
      end
      if (eff_drag && (pt_rd > best_t)) begin
        best_t     <= pt_rd;
        best_idx   <= idx;
        best_found <= 1'b1;
      end
    end
  end

  // Result builder.
  always_comb begin
    res.modifier_code = mod_code(cur.shift_held, cur.alt_held, cur.ctrl_held);
    res.out_x         = cur.pos_x;
    res.out_y         = cur.pos_y;
    res.last_of_run   = 1'b1;
    res.gesture_button = cur.button;
    res.gesture       = G_DOUBLE;
    case (cmd.kind)
      EK_START: begin
        res.gesture        = G_DRAG_START;
        res.gesture_button = 2'(idx);
        res.out_x          = ax_rd;
        res.out_y          = ay_rd;
        res.last_of_run    = 1'b0;
      end
      EK_FINAL: begin
        if (best_found) begin
          res.gesture        = G_DRAG;
          res.gesture_button = 2'(best_idx);
        end else begin
          res.gesture        = G_MOVE;
          res.gesture_button = BTN_NONE;
        end
      end
      default: begin
        if (cur.operation == OP_RELEASE) begin
          if (drag_rd) begin
            res.gesture = G_DRAG_END;
          end else begin
            res.gesture = G_CLICK;
            res.out_x   = ax_rd;
            res.out_y   = ay_rd;
          end
        end
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp_data <= res;
    end
  end

endmodule

[src/pcdc_checker.sv]
`include "assert_macros.svh"

module pcdc_checker import pcdc_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  // A stalled result stays offered and unchanged.
  `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

  // A drag start is never marked as the last result of its request.
  `ASSERT_CLK(a_start_not_last, rsp_valid && (rsp_data.gesture == G_DRAG_START) |-> !rsp_data.last_of_run)

  // A plain move names no button.
  `ASSERT_CLK(a_move_no_button, rsp_valid && (rsp_data.gesture == G_MOVE) |-> rsp_data.gesture_button == BTN_NONE)

  // Nothing is offered right after reset.
  `ASSERT_ALWAYS(a_reset_empty, $past(rst) && !rst |-> !rsp_valid)

endmodule

bind pointer_click_drag_classifier pcdc_checker u_pcdc_checker (.*);

[verif/tb_pointer_click_drag_classifier.sv]
`timescale 1ns / 1ps

module tb_pointer_click_drag_classifier;
  import pcdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int EVENTS_PER_PHASE = 24;

  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_RIGHT  = 2'd1;
  localparam logic [1:0] BTN_MIDDLE = 2'd2;

  localparam logic [2:0] MC_NONE       = 3'd0;
  localparam logic [2:0] MC_SHIFT      = 3'd1;
  localparam logic [2:0] MC_ALT        = 3'd2;
  localparam logic [2:0] MC_CTRL       = 3'd3;
  localparam logic [2:0] MC_SHIFT_ALT  = 3'd4;
  localparam logic [2:0] MC_CTRL_ALT   = 3'd5;
  localparam logic [2:0] MC_CTRL_SHIFT = 3'd6;
  localparam logic [2:0] MC_ALL        = 3'd7;

  // Modifier flag sets, ordered {ctrl, alt, shift}.
  localparam logic [2:0] KEYS_NONE  = 3'b000;
  localparam logic [2:0] KEYS_SHIFT = 3'b001;
  localparam logic [2:0] KEYS_ALT   = 3'b010;
  localparam logic [2:0] KEYS_SA    = 3'b011;
  localparam logic [2:0] KEYS_CTRL  = 3'b100;
  localparam logic [2:0] KEYS_CS    = 3'b101;
  localparam logic [2:0] KEYS_CA    = 3'b110;
  localparam logic [2:0] KEYS_ALL   = 3'b111;

  typedef struct {
    req_t req;
    bit   typed;
    bit   has_want;
    rsp_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_ready;
  req_t              req_data = '0;
  logic              rsp_valid;
  logic              rsp_ready = 1'b0;
  rsp_t              rsp_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pointer_click_drag_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Tracked button state and register copies as seen by the gesture predictor.
  logic        btn_held    [BUTTON_COUNT] = '{default: 1'b0};
  logic        btn_dragged [BUTTON_COUNT] = '{default: 1'b0};
  coord_t      anchor_px   [BUTTON_COUNT] = '{default: '1};
  coord_t      anchor_py   [BUTTON_COUNT] = '{default: '1};
  logic [31:0] pressed_at  [BUTTON_COUNT] = '{default: '0};
  logic [15:0] cfg_threshold = THRESHOLD_RESET;
  logic [31:0] cfg_delay     = DELAY_RESET;

  rsp_t      expected_gestures [$];
  stim_row_t directed_rows [$];
  int        mismatches = 0;
  int        events_sent = 0;
  int        burst_left = 0;

  // Pointer walk used by the random gestures.
  int          cursor_x = 0;
  int          cursor_y = 0;
  logic [31:0] clock_ms = 32'd1000;

  function automatic req_t mk_req(logic [1:0] op, logic [1:0] btn, int x, int y,
                                  logic [31:0] t, logic [2:0] keys);
    req_t r;
    r.operation  = op;
    r.button     = btn;
    r.pos_x      = coord_t'(x);
    r.pos_y      = coord_t'(y);
    r.now_ms     = t;
    r.shift_held = keys[0];
    r.alt_held   = keys[1];
    r.ctrl_held  = keys[2];
    return r;
  endfunction

  function automatic rsp_t mk_rsp(logic [2:0] g, logic [1:0] btn, int x, int y,
                                  logic [2:0] mc, logic last);
    rsp_t r;
    r.gesture        = g;
    r.gesture_button = btn;
    r.out_x          = coord_t'(x);
    r.out_y          = coord_t'(y);
    r.modifier_code  = mc;
    r.last_of_run    = last;
    return r;
  endfunction

  function automatic logic [2:0] modifier_code_of(logic s, logic a, logic c);
    case ({c, a, s})
      KEYS_NONE:  return MC_NONE;
      KEYS_SHIFT: return MC_SHIFT;
      KEYS_ALT:   return MC_ALT;
      KEYS_CTRL:  return MC_CTRL;
      KEYS_SA:    return MC_SHIFT_ALT;
      KEYS_CA:    return MC_CTRL_ALT;
      KEYS_CS:    return MC_CTRL_SHIFT;
      default:    return MC_ALL;
    endcase
  endfunction

  // Works out the gestures one pointer request causes and updates the button state.
  function automatic void classify_event(req_t r, ref rsp_t res[$]);
    logic [2:0]  mc;
    logic [31:0] held_for;
    logic [31:0] best_ms;
    int          best;
    int          dx;
    int          dy;
    int          b;
    res.delete();
    mc = modifier_code_of(r.shift_held, r.alt_held, r.ctrl_held);
    if (r.operation == OP_MOVE) begin
      // Promote pressed buttons that moved far enough or were held long enough.
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (btn_held[i] && !btn_dragged[i]) begin
          held_for = r.now_ms - pressed_at[i];
          dx = int'(r.pos_x) - int'(anchor_px[i]);
          dy = int'(r.pos_y) - int'(anchor_py[i]);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          if (held_for >= cfg_delay || dx >= int'(cfg_threshold) ||
              dy >= int'(cfg_threshold)) begin
            btn_dragged[i] = 1'b1;
            res.push_back(mk_rsp(G_DRAG_START, 2'(i), int'(anchor_px[i]),
                                 int'(anchor_py[i]), mc, 1'b0));
          end
        end
      end
      // The latest started drag wins; a start time of zero never qualifies.
      best = -1;
      best_ms = '0;
      for (int i = 0; i < BUTTON_COUNT; i++) begin
        if (btn_dragged[i] && pressed_at[i] > best_ms) begin
          best_ms = pressed_at[i];
          best = i;
        end
      end
      if (best >= 0)
        res.push_back(mk_rsp(G_DRAG, 2'(best), int'(r.pos_x), int'(r.pos_y), mc, 1'b0));
      else
        res.push_back(mk_rsp(G_MOVE, BTN_NONE, int'(r.pos_x), int'(r.pos_y), mc, 1'b0));
    end else begin
      if (r.button == BTN_NONE || int'(r.button) >= BUTTON_COUNT) return;
      b = int'(r.button);
      if (r.operation == OP_PRESS) begin
        btn_held[b]   = 1'b1;
        anchor_px[b]  = r.pos_x;
        anchor_py[b]  = r.pos_y;
        pressed_at[b] = r.now_ms;
      end else if (r.operation == OP_RELEASE) begin
        if (btn_dragged[b]) begin
          res.push_back(mk_rsp(G_DRAG_END, r.button, int'(r.pos_x), int'(r.pos_y),
                               mc, 1'b0));
          btn_dragged[b] = 1'b0;
          btn_held[b]    = 1'b0;
        end else if (btn_held[b]) begin
          res.push_back(mk_rsp(G_CLICK, r.button, int'(anchor_px[b]),
                               int'(anchor_py[b]), mc, 1'b0));
          btn_held[b] = 1'b0;
        end
      end else begin
        res.push_back(mk_rsp(G_DOUBLE, r.button, int'(r.pos_x), int'(r.pos_y), mc, 1'b0));
      end
    end
    if (res.size() > 0) res[res.size() - 1].last_of_run = 1'b1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sender works in bursts; a gap of idle cycles separates consecutive bursts.
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 12);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [2:0] rand_keys();
    return 3'($urandom_range(0, 7));
  endfunction

  // Issues one request and records what it should produce once it is taken.
  task automatic send(req_t r, int gap, bit typed = 1'b0, bit has_want = 1'b0,
                      rsp_t want = '0);
    rsp_t got [$];
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    classify_event(r, got);
    if (typed) begin
      if (has_want) expected_gestures.push_back(want);
    end else begin
      foreach (got[k]) expected_gestures.push_back(got[k]);
    end
    if (r.operation == OP_MOVE || r.button != BTN_NONE) events_sent++;
  endtask

  // Holds the request side until every predicted gesture has come out.
  task automatic wait_gestures_done();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_gestures.size() != 0) @(posedge clk);
  endtask

  // APB write followed by a read back of the same register.
  task automatic reg_write(logic idx, logic [31:0] val);
    logic [31:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_THRESHOLD) begin
      cfg_threshold = val[15:0];
      stored = {16'h0, val[15:0]};
    end else begin
      cfg_delay = val;
      stored = val;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("register readback", stored, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Next move of a gesture, often placed right on the time or distance limit.
  function automatic req_t random_move(int px, int py, logic [31:0] pt);
    case ($urandom_range(0, 9))
      0: clock_ms = pt + cfg_delay;
      1: clock_ms = pt + cfg_delay - 32'd1;
      2: begin
        cursor_x = px + int'(cfg_threshold);
        cursor_y = py;
      end
      3: begin
        cursor_x = px;
        cursor_y = py - int'(cfg_threshold) + 1;
      end
      default: begin
        cursor_x += int'($urandom_range(0, 8)) - 4;
        cursor_y += int'($urandom_range(0, 8)) - 4;
        clock_ms += $urandom_range(0, 150);
      end
    endcase
    return mk_req(OP_MOVE, 2'($urandom_range(0, 3)), cursor_x, cursor_y, clock_ms,
                  rand_keys());
  endfunction

  // Noise: every field drawn over its whole range.
  function automatic req_t random_noise();
    req_t r;
    r.operation  = 2'($urandom);
    r.button     = 2'($urandom);
    r.pos_x      = coord_t'($urandom);
    r.pos_y      = coord_t'($urandom);
    r.now_ms     = $urandom;
    r.shift_held = 1'($urandom);
    r.alt_held   = 1'($urandom);
    r.ctrl_held  = 1'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      cursor_x = int'(r.pos_x);
      cursor_y = int'(r.pos_y);
    end
    return r;
  endfunction

  // Press, a few moves with the odd extra press, then a release or the odd double click, mostly of the same button.
  task automatic run_gesture();
    logic [1:0]  b;
    int          px;
    int          py;
    logic [31:0] pt;
    b  = 2'($urandom_range(0, BUTTON_COUNT - 1));
    px = cursor_x;
    py = cursor_y;
    pt = clock_ms;
    send(mk_req(OP_PRESS, b, px, py, pt, rand_keys()), next_gap());
    repeat ($urandom_range(1, 4)) begin
      send(random_move(px, py, pt), next_gap());
      if ($urandom_range(0, 4) == 0)
        send(mk_req(OP_PRESS, 2'($urandom_range(0, 2)), cursor_x, cursor_y, clock_ms,
                    rand_keys()), next_gap());
    end
    if ($urandom_range(0, 9) == 0) b = 2'($urandom_range(0, 3));
    send(mk_req(($urandom_range(0, 5) == 0) ? OP_DOUBLE : OP_RELEASE, b, cursor_x,
                cursor_y, clock_ms, rand_keys()), next_gap());
  endtask

  task automatic run_phase(logic [15:0] thr, logic [31:0] delay);
    wait_gestures_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(REG_THRESHOLD, {16'h0, thr});
    reg_write(REG_DELAY, delay);
    events_sent = 0;
    while (events_sent < EVENTS_PER_PHASE) begin
      if ($urandom_range(0, 9) < 7) run_gesture();
      else send(random_noise(), next_gap());
    end
  endtask

  // Receiver stall pattern: stretches of always ready, random stalls and a fixed rhythm.
  int ready_mode  = 0;
  int ready_count = 0;
  always @(posedge clk) begin
    if (ready_count == 0) begin
      ready_mode  = $urandom_range(0, 3);
      ready_count = $urandom_range(10, 60);
    end else begin
      ready_count--;
    end
    case (ready_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      2: rsp_ready <= ($urandom_range(0, 3) == 0);
      default: rsp_ready <= (ready_count % 4 != 0);
    endcase
  end

  // Compare each gesture that leaves the block with the oldest prediction.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_gestures.size() == 0) begin
        $error("gesture with nothing predicted: %p", rsp_data);
        mismatches++;
      end else begin
        want = expected_gestures.pop_front();
        check_field("gesture", want.gesture, rsp_data.gesture);
        check_field("gesture_button", want.gesture_button, rsp_data.gesture_button);
        check_field("out_x", want.out_x, rsp_data.out_x);
        check_field("out_y", want.out_y, rsp_data.out_y);
        check_field("modifier_code", want.modifier_code, rsp_data.modifier_code);
        check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
      end
    end
  end

  // Ends the run when no request, gesture or register access moves for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // Directed table, run with the reset register values.
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_LEFT, 32767, -32768, 32'h0, KEYS_NONE),
      1'b1, 1'b1, mk_rsp(G_MOVE, BTN_NONE, 32767, -32768, MC_NONE, 1'b1)});
    directed_rows.push_back('{mk_req(OP_DOUBLE, BTN_MIDDLE, -32768, 32767, 32'hFFFF_FFFF,
      KEYS_ALL), 1'b1, 1'b1, mk_rsp(G_DOUBLE, BTN_MIDDLE, -32768, 32767, MC_ALL, 1'b1)});
    // Untracked button and release of an idle button give nothing.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_NONE, 3, 3, 32'd10, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RELEASE, BTN_LEFT, 3, 3, 32'd11, KEYS_NONE),
      1'b1, 1'b0, '0});
    // Short press and release: a click at the start point.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_LEFT, 10, 10, 32'd1000, KEYS_SHIFT),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_LEFT, 11, 12, 32'd1001, KEYS_SHIFT),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RELEASE, BTN_LEFT, 12, 12, 32'd1002, KEYS_NONE),
      1'b0, 1'b0, '0});
    // Drag by distance exactly at the threshold, then by hold time exactly at the delay.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_RIGHT, -5, -5, 32'd2000, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_RIGHT, -1, -5, 32'd2001, KEYS_ALT),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_LEFT, 100, 100, 32'd2500, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_LEFT, 100, 100, 32'd2800, KEYS_NONE),
      1'b0, 1'b0, '0});
    // A start time of zero is never picked for the drag report.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_MIDDLE, 0, 0, 32'd0, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_MIDDLE, 50, 0, 32'd2900, KEYS_CTRL),
      1'b0, 1'b0, '0});
    // Repeated press of a dragged button re-arms its start and keeps the drag.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_RIGHT, 7, 7, 32'd3000, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_RIGHT, 7, 7, 32'd3001, KEYS_NONE),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RELEASE, BTN_RIGHT, 8, 9, 32'd3002, KEYS_CTRL),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RELEASE, BTN_LEFT, 9, 9, 32'd3003, KEYS_NONE),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RELEASE, BTN_MIDDLE, 9, 9, 32'd3004, KEYS_NONE),
      1'b0, 1'b0, '0});
    // Hold time across the 32-bit wrap: one below the delay, then exactly at it.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_LEFT, 0, 0, 32'hFFFF_FF00, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_LEFT, 0, 0, 32'h0000_002B, KEYS_NONE),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_LEFT, 0, 0, 32'h0000_002C, KEYS_NONE),
      1'b0, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_RELEASE, BTN_LEFT, 1, 1, 32'h0000_002D, KEYS_NONE),
      1'b0, 1'b0, '0});
    // Three buttons start together: three drag starts and a tie won by the lowest index.
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_LEFT, 0, 0, 32'd500, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_RIGHT, 0, 0, 32'd500, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_PRESS, BTN_MIDDLE, 0, 0, 32'd500, KEYS_NONE),
      1'b1, 1'b0, '0});
    directed_rows.push_back('{mk_req(OP_MOVE, BTN_LEFT, 10, 0, 32'd501, KEYS_CA),
      1'b0, 1'b0, '0});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k])
      send(directed_rows[k].req, next_gap(), directed_rows[k].typed,
           directed_rows[k].has_want, directed_rows[k].want);

    // Random gestures under several register settings, extremes first.
    run_phase(16'h0000, 32'hFFFF_FFFF);
    run_phase(16'hFFFF, 32'h0000_0000);
    run_phase(16'($urandom_range(1, 16)), $urandom_range(50, 1000));
    run_phase(16'hFFFF, 32'hFFFF_FFFF);
    run_phase(THRESHOLD_RESET, DELAY_RESET);

    wait_gestures_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_gestures.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
